### sv/afb_pkg.sv
// Shared types, constants and arithmetic helpers of the activation core.
`timescale 1ns / 1ps
`default_nettype none

package afb_pkg;

	// Number formats
	localparam int FRAC_BITS    = 12;
	localparam int SLOPE_BITS   = 12;
	localparam int DATA_W       = 16;
	localparam int SLOPE_W      = 13;
	localparam int SLOPE_PROD_W = DATA_W + SLOPE_W;
	localparam int ARG_W        = DATA_W + 1;
	localparam int YY_W         = DATA_W + ARG_W;
	localparam int PROD_W       = DATA_W + YY_W;

	typedef logic signed [DATA_W-1:0]       data_t;
	typedef logic signed [SLOPE_PROD_W-1:0] slope_prod_t;
	typedef logic signed [YY_W-1:0]         yy_t;
	typedef logic signed [PROD_W-1:0]       prod_t;
	typedef logic [SLOPE_W-1:0]             slope_t;

	localparam slope_t SLOPE_RESET = SLOPE_W'(819);

	// Operation codes
	localparam logic KIND_BACKWARD = 1'b1;

	localparam logic [2:0] MODE_SIGMOID = 3'd0;
	localparam logic [2:0] MODE_LINEAR  = 3'd1;
	localparam logic [2:0] MODE_RELU    = 3'd2;
	localparam logic [2:0] MODE_LEAKY   = 3'd3;
	localparam logic [2:0] MODE_TANH    = 3'd4;

	// Where the final value of an item comes from
	typedef logic [1:0] src_t;
	localparam src_t SRC_DIRECT = 2'd0;
	localparam src_t SRC_SLOPE  = 2'd1;
	localparam src_t SRC_DERIV  = 2'd2;

	typedef struct packed {
		src_t src;
		logic is_tanh;
	} s1_ctl_t;

	// Fixed-point constants
	localparam data_t ONE_D = DATA_W'(1 << FRAC_BITS);
	localparam logic signed [ARG_W-1:0] ONE_ARG = ARG_W'(1 << FRAC_BITS);
	localparam yy_t ONE_SQ = YY_W'(1 << (2 * FRAC_BITS));

	// Piecewise sigmoid breakpoints and offsets
	localparam logic [ARG_W-1:0] PLAN_ONE   = ARG_W'(1 << FRAC_BITS);
	localparam logic [ARG_W-1:0] PLAN_T_HI  = ARG_W'(5 * (1 << FRAC_BITS));
	localparam logic [ARG_W-1:0] PLAN_T_MID = ARG_W'((19 * (1 << FRAC_BITS)) / 8);
	localparam logic [ARG_W-1:0] PLAN_OFF_HI  = ARG_W'((27 * (1 << FRAC_BITS)) / 32);
	localparam logic [ARG_W-1:0] PLAN_OFF_MID = ARG_W'((5 * (1 << FRAC_BITS)) / 8);
	localparam logic [ARG_W-1:0] PLAN_OFF_LO  = ARG_W'((1 << FRAC_BITS) / 2);

	// Saturation bounds
	localparam prod_t SAT_MAX = PROD_W'(32767);
	localparam prod_t SAT_MIN = -PROD_W'(32768);

	// Piecewise-linear sigmoid of a signed argument
	function automatic data_t plan_sigmoid(input logic signed [ARG_W-1:0] v);
		logic [ARG_W-1:0] a;
		logic [ARG_W-1:0] m;
		a = v;
		if (v[ARG_W-1]) begin
			a = ~a + ARG_W'(1);
		end
		if (a >= PLAN_T_HI) begin
			m = PLAN_ONE;
		end else if (a >= PLAN_T_MID) begin
			m = (a >> 5) + PLAN_OFF_HI;
		end else if (a >= PLAN_ONE) begin
			m = (a >> 3) + PLAN_OFF_MID;
		end else begin
			m = (a >> 2) + PLAN_OFF_LO;
		end
		if (v[ARG_W-1]) begin
			m = PLAN_ONE - m;
		end
		return m[DATA_W-1:0];
	endfunction

	// Clamp a wide signed value to the output range
	function automatic data_t sat_data(input prod_t v);
		data_t r;
		r = v[DATA_W-1:0];
		if (v > SAT_MAX) begin
			r = SAT_MAX[DATA_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/afb_front.sv
// First pipeline stage: mode decode, forward activations and first products.
`timescale 1ns / 1ps
`default_nettype none

module afb_front (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic                 kind,
	input  wire logic [2:0]           act_mode,
	input  wire afb_pkg::data_t       pre_value,
	input  wire afb_pkg::data_t       saved_output,
	input  wire afb_pkg::data_t       grad_in,
	input  wire afb_pkg::slope_t      leaky_slope,
	output afb_pkg::s1_ctl_t          ctl_s1,
	output afb_pkg::data_t            direct_s1,
	output afb_pkg::slope_prod_t      slope_prod_s1,
	output afb_pkg::yy_t              yy_s1,
	output afb_pkg::data_t            grad_s1
);

	logic                              back;
	logic                              x_pos;
	logic                              is_tanh;
	afb_pkg::data_t                    pass_val;
	afb_pkg::data_t                    sig_fwd;
	afb_pkg::data_t                    sig_twice;
	afb_pkg::data_t                    tanh_fwd;
	afb_pkg::data_t                    direct;
	afb_pkg::src_t                     src;
	logic signed [afb_pkg::SLOPE_PROD_W:0] slope_full;
	logic signed [afb_pkg::ARG_W-1:0]  y_ext;
	logic signed [afb_pkg::ARG_W-1:0]  yy_arg;
	afb_pkg::yy_t                      yy_full;

	assign back     = (kind == afb_pkg::KIND_BACKWARD);
	assign x_pos    = !pre_value[afb_pkg::DATA_W-1] && (pre_value != '0);
	assign is_tanh  = (act_mode == afb_pkg::MODE_TANH);
	assign pass_val = back ? grad_in : pre_value;

	// Forward sigmoid and tanh through the shared piecewise curve
	assign sig_fwd   = afb_pkg::plan_sigmoid({pre_value[afb_pkg::DATA_W-1], pre_value});
	assign sig_twice = afb_pkg::plan_sigmoid({pre_value, 1'b0});
	assign tanh_fwd  = {sig_twice[afb_pkg::DATA_W-2:0], 1'b0} - afb_pkg::ONE_D;

	// Pick the value that needs no multiply, and the source of the final value
	always_comb begin
		direct = '0;
		src    = afb_pkg::SRC_DIRECT;
		case (act_mode)
			afb_pkg::MODE_SIGMOID: begin
				if (back) begin
					src = afb_pkg::SRC_DERIV;
				end else begin
					direct = sig_fwd;
				end
			end
			afb_pkg::MODE_LINEAR: begin
				direct = pass_val;
			end
			afb_pkg::MODE_RELU: begin
				if (x_pos) begin
					direct = pass_val;
				end
			end
			afb_pkg::MODE_LEAKY: begin
				if (x_pos) begin
					direct = pass_val;
				end else begin
					src = afb_pkg::SRC_SLOPE;
				end
			end
			afb_pkg::MODE_TANH: begin
				if (back) begin
					src = afb_pkg::SRC_DERIV;
				end else begin
					direct = tanh_fwd;
				end
			end
			default: begin
				direct = '0;
			end
		endcase
	end

	// Leaky slope product, of x forward and of g backward
	assign slope_full = $signed({{(afb_pkg::SLOPE_W + 1){pass_val[afb_pkg::DATA_W-1]}}, pass_val})
		* $signed({{(afb_pkg::DATA_W + 1){1'b0}}, leaky_slope});

	// y*(1-y) for sigmoid, y*y for tanh
	assign y_ext   = {saved_output[afb_pkg::DATA_W-1], saved_output};
	assign yy_arg  = is_tanh ? y_ext : (afb_pkg::ONE_ARG - y_ext);
	assign yy_full = $signed({{afb_pkg::ARG_W{saved_output[afb_pkg::DATA_W-1]}}, saved_output})
		* $signed({{afb_pkg::DATA_W{yy_arg[afb_pkg::ARG_W-1]}}, yy_arg});

	// Stage register
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.src     <= src;
			ctl_s1.is_tanh <= is_tanh;
			direct_s1      <= direct;
			slope_prod_s1  <= slope_full[afb_pkg::SLOPE_PROD_W-1:0];
			yy_s1          <= yy_full;
			grad_s1        <= grad_in;
		end
	end

endmodule

`default_nettype wire

### sv/afb_grad.sv
// Second and third pipeline stages: slope scaling, derivative factor and gradient product.
`timescale 1ns / 1ps
`default_nettype none

module afb_grad (
	input  wire logic                 clk,
	input  wire logic                 en_s2,
	input  wire logic                 en_s3,
	input  wire afb_pkg::s1_ctl_t     ctl_s1,
	input  wire afb_pkg::data_t       direct_s1,
	input  wire afb_pkg::slope_prod_t slope_prod_s1,
	input  wire afb_pkg::yy_t         yy_s1,
	input  wire afb_pkg::data_t       grad_s1,
	output logic                      use_deriv_s3,
	output afb_pkg::data_t            merged_s3,
	output afb_pkg::prod_t            deriv_prod_s3
);

	afb_pkg::slope_prod_t slope_shift;
	afb_pkg::data_t       slope_val;
	afb_pkg::data_t       merged;
	afb_pkg::yy_t         factor;
	afb_pkg::prod_t       deriv_prod;

	logic                 use_deriv_s2;
	afb_pkg::data_t       merged_s2;
	afb_pkg::yy_t         factor_s2;
	afb_pkg::data_t       grad_s2;

	// Scale by the slope with floor rounding, then clamp
	assign slope_shift = slope_prod_s1 >>> afb_pkg::SLOPE_BITS;
	assign slope_val   = afb_pkg::sat_data(
		{{(afb_pkg::PROD_W - afb_pkg::SLOPE_PROD_W){slope_shift[afb_pkg::SLOPE_PROD_W-1]}},
		slope_shift});
	assign merged = (ctl_s1.src == afb_pkg::SRC_SLOPE) ? slope_val : direct_s1;

	// Local derivative: y*(1-y) as is, 1-y*y for tanh
	assign factor = ctl_s1.is_tanh ? (afb_pkg::ONE_SQ - yy_s1) : yy_s1;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			use_deriv_s2 <= (ctl_s1.src == afb_pkg::SRC_DERIV);
			merged_s2    <= merged;
			factor_s2    <= factor;
			grad_s2      <= grad_s1;
		end
	end

	// Gradient times derivative, kept exact
	assign deriv_prod = $signed({{afb_pkg::YY_W{grad_s2[afb_pkg::DATA_W-1]}}, grad_s2})
		* $signed({{afb_pkg::DATA_W{factor_s2[afb_pkg::YY_W-1]}}, factor_s2});

	always_ff @(posedge clk) begin
		if (en_s3) begin
			use_deriv_s3  <= use_deriv_s2;
			merged_s3     <= merged_s2;
			deriv_prod_s3 <= deriv_prod;
		end
	end

endmodule

`default_nettype wire

### sv/activation_forward_backward_core.sv
// Top level of the activation core: handshakes, slope register, pipeline control, output stage.
`timescale 1ns / 1ps
`default_nettype none

// Element-wise activation unit in signed Q3.12. Each beat carries one value and
// selects forward (activation of pre_value) or backward (grad_in times the local
// derivative) for sigmoid, linear, ReLU, leaky ReLU or tanh; every result is
// saturated to 16 bits. The core is a four-stage pipeline and takes one beat per
// clock while in_ready is high: an accepted beat is registered in s1, s2, s3 and
// s4 in turn, and out_valid is valid_s4. Every stage takes a new beat each clock
// unless the output stall reaches it, so nothing repeats per item; the longest
// stage is the one that holds the 16 x 33 gradient multiplier. in_ready drops
// only when all four stages hold beats and out_ready is low; empty stages close up
// under a stall. leaky_slope is written through the cfg channel, which is always
// ready, and should be written only while the pipeline is empty.
module activation_forward_backward_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Configuration channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire afb_pkg::slope_t     cfg_data,
	// Input channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                kind,
	input  wire logic [2:0]          act_mode,
	input  wire afb_pkg::data_t      pre_value,
	input  wire afb_pkg::data_t      saved_output,
	input  wire afb_pkg::data_t      grad_in,
	// Output channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output afb_pkg::data_t           result
);

	afb_pkg::slope_t      leaky_slope_q;

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 valid_s3;
	logic                 valid_s4;
	logic                 en_s1;
	logic                 en_s2;
	logic                 en_s3;
	logic                 en_s4;

	afb_pkg::s1_ctl_t     ctl_s1;
	afb_pkg::data_t       direct_s1;
	afb_pkg::slope_prod_t slope_prod_s1;
	afb_pkg::yy_t         yy_s1;
	afb_pkg::data_t       grad_s1;
	logic                 use_deriv_s3;
	afb_pkg::data_t       merged_s3;
	afb_pkg::prod_t       deriv_prod_s3;
	afb_pkg::prod_t       deriv_shift;
	afb_pkg::data_t       result_s4;

	// Slope register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaky_slope_q <= afb_pkg::SLOPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			leaky_slope_q <= cfg_data;
		end
	end

	// Advance a stage when it is empty or its contents move on
	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	afb_front u_front (
		.clk           (clk),
		.en            (en_s1),
		.kind          (kind),
		.act_mode      (act_mode),
		.pre_value     (pre_value),
		.saved_output  (saved_output),
		.grad_in       (grad_in),
		.leaky_slope   (leaky_slope_q),
		.ctl_s1        (ctl_s1),
		.direct_s1     (direct_s1),
		.slope_prod_s1 (slope_prod_s1),
		.yy_s1         (yy_s1),
		.grad_s1       (grad_s1)
	);

	afb_grad u_grad (
		.clk           (clk),
		.en_s2         (en_s2),
		.en_s3         (en_s3),
		.ctl_s1        (ctl_s1),
		.direct_s1     (direct_s1),
		.slope_prod_s1 (slope_prod_s1),
		.yy_s1         (yy_s1),
		.grad_s1       (grad_s1),
		.use_deriv_s3  (use_deriv_s3),
		.merged_s3     (merged_s3),
		.deriv_prod_s3 (deriv_prod_s3)
	);

	// Drop the fraction of the gradient product, clamp and hold for output
	assign deriv_shift = deriv_prod_s3 >>> (2 * afb_pkg::FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			result_s4 <= use_deriv_s3 ? afb_pkg::sat_data(deriv_shift) : merged_s3;
		end
	end

	assign out_valid = valid_s4;
	assign result    = result_s4;

	// A stalled input means every stage holds a beat behind a blocked output
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && !out_ready))
		else $error("input stalled while the pipeline has room");

	// An accepted beat lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted beat lost at the first stage");

	// A beat in the third stage is never dropped while the output is blocked
	a_s3_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && valid_s4 && !out_ready) |=> (valid_s3 && valid_s4))
		else $error("beat dropped under an output stall");

	// A slope write takes effect on the next cycle
	a_slope_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (leaky_slope_q == $past(cfg_data)))
		else $error("slope register missed a write");

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the activation core: directed and random beats, slope sweep, stalls.
`timescale 1ns / 1ps

module tb_top;

	localparam longint UNIT       = longint'(1) << afb_pkg::FRAC_BITS;
	localparam logic   KIND_FWD   = 1'b0;
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_MID = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam int     PHASES     = 6;
	localparam int     PHASE_BEATS = 150;
	localparam int     HOLD_PHASE = 2;
	localparam int     HOLD_CYCLES = 200;

	// Expected activations and gradients, with a private copy of the slope
	class result_board;
		afb_pkg::data_t  expected_results[$];
		afb_pkg::slope_t slope;
		int     errors;
		int     checked;

		function new();
			slope = afb_pkg::SLOPE_RESET;
			errors = 0;
			checked = 0;
		endfunction

		// Piecewise-linear sigmoid on a wide argument
		function longint sig_plan(longint v);
			longint a;
			longint m;
			a = (v < 0) ? -v : v;
			if (a >= 5 * UNIT) begin
				m = UNIT;
			end else if (a >= (19 * UNIT) / 8) begin
				m = (a >>> 5) + (27 * UNIT) / 32;
			end else if (a >= UNIT) begin
				m = (a >>> 3) + (5 * UNIT) / 8;
			end else begin
				m = (a >>> 2) + UNIT / 2;
			end
			return (v < 0) ? UNIT - m : m;
		endfunction

		// Activation or input gradient of one beat, floored and clamped
		function afb_pkg::data_t activation_of(logic k, logic [2:0] m, afb_pkg::data_t x,
				afb_pkg::data_t y, afb_pkg::data_t g);
			longint xv;
			longint yv;
			longint gv;
			longint s;
			longint r;
			xv = x;
			yv = y;
			gv = g;
			s = longint'(slope);
			r = 0;
			if (k == afb_pkg::KIND_BACKWARD) begin
				case (m)
					afb_pkg::MODE_SIGMOID:
						r = (gv * yv * (UNIT - yv)) >>> (2 * afb_pkg::FRAC_BITS);
					afb_pkg::MODE_LINEAR:  r = gv;
					afb_pkg::MODE_RELU:    r = (xv > 0) ? gv : 0;
					afb_pkg::MODE_LEAKY:
						r = (xv > 0) ? gv : ((gv * s) >>> afb_pkg::SLOPE_BITS);
					afb_pkg::MODE_TANH:
						r = (gv * (UNIT * UNIT - yv * yv)) >>> (2 * afb_pkg::FRAC_BITS);
					default:      r = 0;
				endcase
			end else begin
				case (m)
					afb_pkg::MODE_SIGMOID: r = sig_plan(xv);
					afb_pkg::MODE_LINEAR:  r = xv;
					afb_pkg::MODE_RELU:    r = (xv > 0) ? xv : 0;
					afb_pkg::MODE_LEAKY:
						r = (xv > 0) ? xv : ((xv * s) >>> afb_pkg::SLOPE_BITS);
					afb_pkg::MODE_TANH:    r = 2 * sig_plan(2 * xv) - UNIT;
					default:      r = 0;
				endcase
			end
			if (r > 32767) begin
				r = 32767;
			end else if (r < -32768) begin
				r = -32768;
			end
			return afb_pkg::data_t'(r);
		endfunction

		function void note_beat(logic k, logic [2:0] m, afb_pkg::data_t x,
				afb_pkg::data_t y, afb_pkg::data_t g);
			expected_results.insert(expected_results.size(), activation_of(k, m, x, y, g));
		endfunction

		function void check_beat(afb_pkg::data_t got);
			afb_pkg::data_t want;
			checked++;
			if (expected_results.size() == 0) begin
				errors++;
				$error("result with nothing expected: actual %0d", got);
				return;
			end
			want = expected_results.pop_front();
			if (got !== want) begin
				errors++;
				$error("result mismatch: expected %0d, actual %0d", want, got);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	afb_pkg::slope_t cfg_data = '0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	logic            kind = 1'b0;
	logic [2:0]      act_mode = '0;
	afb_pkg::data_t  pre_value = '0;
	afb_pkg::data_t  saved_output = '0;
	afb_pkg::data_t  grad_in = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	afb_pkg::data_t  result;

	result_board board;
	bit          idle_on = 1'b1;
	bit          hold_req = 1'b0;
	int          beats_sent = 0;
	int          input_stalls = 0;
	int          slopes_used = 0;

	activation_forward_backward_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.act_mode     (act_mode),
		.pre_value    (pre_value),
		.saved_output (saved_output),
		.grad_in      (grad_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result       (result)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check every result beat and count cycles in which the input is held off
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_beat(result);
		end
		if (arst_n && in_valid && !in_ready) begin
			input_stalls++;
		end
	end

	// Receiver: ready runs, stall bursts, and one long hold-off on request
	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Offer one beat, hold it until taken, then maybe pause the sender
	task automatic send_beat(input logic k, input logic [2:0] m, input afb_pkg::data_t x,
			input afb_pkg::data_t y, input afb_pkg::data_t g);
		in_valid <= 1'b1;
		kind <= k;
		act_mode <= m;
		pre_value <= x;
		saved_output <= y;
		grad_in <= g;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_beat(k, m, x, y, g);
		beats_sent++;
		if (idle_on && !hold_req && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic write_slope(input afb_pkg::slope_t v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.slope = v;
		slopes_used++;
		cfg_valid <= 1'b0;
	endtask

	// Every beat yields a result, so an empty store means an empty pipeline
	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Q3.12 values weighted towards the breakpoints and the unit range
	function automatic afb_pkg::data_t draw_q312();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return afb_pkg::data_t'(-32768);
					1: return afb_pkg::data_t'(32767);
					2: return afb_pkg::data_t'(0);
					3: return afb_pkg::data_t'(-1);
					default: return afb_pkg::data_t'(1);
				endcase
			end
			1, 2, 3: return afb_pkg::data_t'(int'($urandom_range(0, 2 * UNIT)) - int'(UNIT));
			4, 5, 6:
				return afb_pkg::data_t'(int'($urandom_range(0, 12 * UNIT)) - int'(6 * UNIT));
			default: return afb_pkg::data_t'($urandom);
		endcase
	endfunction

	task automatic send_random();
		logic       k;
		logic [2:0] m;
		k = logic'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0) begin
			m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		end else begin
			m = 3'($urandom_range(afb_pkg::MODE_SIGMOID, afb_pkg::MODE_TANH));
		end
		send_beat(k, m, draw_q312(), draw_q312(), draw_q312());
	endtask

	// Main sequence
	initial begin
		afb_pkg::slope_t settings[PHASES];
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats under the reset slope
		send_beat(KIND_FWD, afb_pkg::MODE_SIGMOID, 16'sd32767, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_SIGMOID, -16'sd32768, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_SIGMOID, 16'sd9728, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_SIGMOID, -16'sd4096, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_SIGMOID, 16'sd0, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_LINEAR, -16'sd32768, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_RELU, 16'sd0, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_RELU, 16'sd32767, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_LEAKY, 16'sd0, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_LEAKY, -16'sd32768, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_TANH, 16'sd20480, '0, '0);
		send_beat(KIND_FWD, afb_pkg::MODE_TANH, -16'sd2048, '0, '0);
		send_beat(KIND_FWD, MODE_SPARE_LO, 16'sd1234, 16'sd77, 16'sd99);
		send_beat(KIND_FWD, MODE_SPARE_HI, -16'sd1, -16'sd1, -16'sd1);
		send_beat(afb_pkg::KIND_BACKWARD, afb_pkg::MODE_SIGMOID, '0, 16'sd2048, 16'sd32767);
		send_beat(afb_pkg::KIND_BACKWARD, afb_pkg::MODE_SIGMOID, '0, -16'sd32768,
			-16'sd32768);
		send_beat(afb_pkg::KIND_BACKWARD, afb_pkg::MODE_LINEAR, '0, '0, -16'sd32768);
		send_beat(afb_pkg::KIND_BACKWARD, afb_pkg::MODE_RELU, 16'sd0, '0, 16'sd1000);
		send_beat(afb_pkg::KIND_BACKWARD, afb_pkg::MODE_RELU, 16'sd1, '0, -16'sd32768);
		send_beat(afb_pkg::KIND_BACKWARD, afb_pkg::MODE_LEAKY, -16'sd1, '0, -16'sd32768);
		send_beat(afb_pkg::KIND_BACKWARD, afb_pkg::MODE_LEAKY, 16'sd5, '0, 16'sd32767);
		send_beat(afb_pkg::KIND_BACKWARD, afb_pkg::MODE_TANH, '0, 16'sd0, -16'sd32768);
		send_beat(afb_pkg::KIND_BACKWARD, afb_pkg::MODE_TANH, '0, -16'sd32768, 16'sd32767);
		send_beat(afb_pkg::KIND_BACKWARD, MODE_SPARE_MID, 16'sd32767, 16'sd32767,
			16'sd32767);
		send_beat(afb_pkg::KIND_BACKWARD, MODE_SPARE_LO, -16'sd32768, 16'sd4096,
			16'sd4096);
		in_valid <= 1'b0;

		// Slope sweep: zero, the 13-bit maximum, unity, two random, reset value
		settings[0] = afb_pkg::slope_t'(0);
		settings[1] = afb_pkg::slope_t'(8191);
		settings[2] = afb_pkg::slope_t'(4096);
		settings[3] = afb_pkg::slope_t'($urandom_range(0, 8191));
		settings[4] = afb_pkg::slope_t'($urandom_range(0, 4096));
		settings[5] = afb_pkg::SLOPE_RESET;
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_slope(settings[p]);
			if (p == PHASES - 1) begin
				idle_on = 1'b0;
			end
			if (p == HOLD_PHASE) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_BEATS; n++) begin
				send_random();
			end
			in_valid <= 1'b0;
		end

		// Drain, then wait for any stray beat
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d beats over %0d slope settings; %0d results checked.",
			beats_sent, slopes_used, board.checked);
		$display("Input held off for %0d cycles; %0d mismatches, %0d results missing.",
			input_stalls, board.errors, board.pending());
		if (board.errors == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
